@@ sv/eot_pkg.sv @@
// eot_pkg: shared widths, register map and reset values of the envelope onset trigger
// used by eot_mul, eot_detect and envelope_onset_trigger
`timescale 1ns / 1ps

package eot_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int COEFF_BITS  = 16;

    localparam int MAG_W   = SAMPLE_BITS + 1;
    localparam int ENV_W   = SAMPLE_BITS + 1 + COEFF_BITS;
    localparam int ENVH_W  = ENV_W - COEFF_BITS;
    localparam int MUL_W   = ((SAMPLE_BITS > COEFF_BITS) ? SAMPLE_BITS : COEFF_BITS) + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int ACC_W   = ENV_W + COEFF_BITS + 1;
    localparam int THR_W   = 16;
    localparam int CD_W    = 16;
    localparam int VEL_W   = SAMPLE_BITS;

    localparam logic [THR_W-1:0] THRESH_MIN = THR_W'(4);
    localparam logic [VEL_W-1:0] VEL_FULL   = VEL_W'(1) << (SAMPLE_BITS - 1);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REG_THRESHOLD = 3'd0,
        REG_ATTACK    = 3'd1,
        REG_RELEASE   = 3'd2,
        REG_COOLDOWN  = 3'd3,
        REG_USE_SEC   = 3'd4
    } t_reg_idx;

    localparam logic [THR_W-1:0]      RST_THRESHOLD = THR_W'(1638);
    localparam logic [COEFF_BITS-1:0] RST_ATTACK    = COEFF_BITS'(64188);
    localparam logic [COEFF_BITS-1:0] RST_RELEASE   = COEFF_BITS'(65519);
    localparam logic [CD_W-1:0]       RST_COOLDOWN  = CD_W'(1920);
    localparam logic                  RST_USE_SEC   = 1'b1;

    typedef struct packed {
        logic [THR_W-1:0] threshold;
        logic [CD_W-1:0]  cooldown_len;
    } t_det_cfg;

endpackage

@@ sv/eot_mul.sv @@
// eot_mul: shared unsigned multiplier with registered product
// depends on eot_pkg for operand widths
`timescale 1ns / 1ps

module eot_mul (
    input  logic                       i_clk,
    input  logic [eot_pkg::MUL_W-1:0]  i_a,
    input  logic [eot_pkg::MUL_W-1:0]  i_b,
    output logic [eot_pkg::PROD_W-1:0] o_prod
);

    logic [eot_pkg::PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= eot_pkg::PROD_W'(i_a) * eot_pkg::PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

@@ sv/eot_detect.sv @@
// eot_detect: onset decision with arm flag and cooldown counter
// depends on eot_pkg for widths and the t_det_cfg struct
`timescale 1ns / 1ps

module eot_detect (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic [eot_pkg::ENV_W-1:0] i_env,
    input  eot_pkg::t_det_cfg         i_cfg,
    output logic                      o_onset
);

    localparam int EW = eot_pkg::ENV_W;
    localparam int CW = eot_pkg::CD_W;

    logic          r_above;
    logic          n_above;
    logic [CW-1:0] r_cooldown;
    logic [CW-1:0] n_cooldown;
    logic [CW-1:0] cd_loaded;
    logic          enabled;
    logic [EW-1:0] thr_full;
    logic [EW-1:0] thr_half;
    logic          onset;

    assign enabled  = i_cfg.threshold >= eot_pkg::THRESH_MIN;
    assign thr_full = EW'(i_cfg.threshold) << eot_pkg::COEFF_BITS;
    assign thr_half = EW'(i_cfg.threshold) << (eot_pkg::COEFF_BITS - 1);
    assign onset    = enabled && !r_above && (i_env >= thr_full) && (r_cooldown == '0);

    always_comb begin
        n_above = r_above;
        if (onset) begin
            n_above = 1'b1;
        end else if (enabled && (i_env < thr_half)) begin
            n_above = 1'b0;
        end
        cd_loaded  = onset ? i_cfg.cooldown_len : r_cooldown;
        n_cooldown = (cd_loaded != '0) ? cd_loaded - CW'(1) : cd_loaded;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_above    <= 1'b0;
            r_cooldown <= '0;
        end else if (i_step) begin
            r_above    <= n_above;
            r_cooldown <= n_cooldown;
        end
    end

    assign o_onset = onset;

endmodule

@@ sv/envelope_onset_trigger.sv @@
// envelope_onset_trigger: peak envelope follower with onset trigger, top level
// depends on eot_pkg, eot_mul and eot_detect
// An item is taken only while the block is idle and then steps through ST_MUL_LO,
// ST_MUL_HI, ST_MUL_LVL, ST_ACC and ST_DET until its result sits in the output register.
// The envelope update a*E + (1-a)*L (r*E alone while falling, as the blend term is then
// zero) runs as three passes through one shared 17x17 multiplier (coefficient times low
// and high envelope halves, then the blend coefficient times the rectified level), then a
// last accumulate and the onset decision. A stalled result holds the decision step until
// the output register frees. Onset velocity is always full scale.
`timescale 1ns / 1ps

module envelope_onset_trigger (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [eot_pkg::SAMPLE_BITS-1:0] i_sample_first,
    input  logic signed [eot_pkg::SAMPLE_BITS-1:0] i_sample_second,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic                                o_onset_pulse,
    output logic [eot_pkg::VEL_W-1:0]           o_velocity,
    output logic [eot_pkg::ENVH_W-1:0]          o_envelope_level,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [eot_pkg::ADDR_W-1:0]          paddr,
    input  logic [eot_pkg::DATA_W-1:0]          pwdata,
    output logic [eot_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int CB = eot_pkg::COEFF_BITS;
    localparam int MW = eot_pkg::MUL_W;
    localparam int PW = eot_pkg::PROD_W;
    localparam int AW = eot_pkg::ACC_W;
    localparam int EW = eot_pkg::ENV_W;
    localparam int HW = eot_pkg::ENVH_W;
    localparam int GW = eot_pkg::MAG_W;
    localparam int DW = eot_pkg::DATA_W;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_MUL_LO  = 6'b000010,
        ST_MUL_HI  = 6'b000100,
        ST_MUL_LVL = 6'b001000,
        ST_ACC     = 6'b010000,
        ST_DET     = 6'b100000
    } t_state;

    // configuration registers
    logic [eot_pkg::THR_W-1:0] r_threshold;
    logic [CB-1:0]             r_attack;
    logic [CB-1:0]             r_release;
    logic [eot_pkg::CD_W-1:0]  r_cooldown_len;
    logic                      r_use_sec;
    logic                      cfg_wr;
    eot_pkg::t_reg_idx         cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = eot_pkg::t_reg_idx'(paddr[4:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold    <= eot_pkg::RST_THRESHOLD;
            r_attack       <= eot_pkg::RST_ATTACK;
            r_release      <= eot_pkg::RST_RELEASE;
            r_cooldown_len <= eot_pkg::RST_COOLDOWN;
            r_use_sec      <= eot_pkg::RST_USE_SEC;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                eot_pkg::REG_THRESHOLD: r_threshold    <= pwdata[eot_pkg::THR_W-1:0];
                eot_pkg::REG_ATTACK:    r_attack       <= pwdata[CB-1:0];
                eot_pkg::REG_RELEASE:   r_release      <= pwdata[CB-1:0];
                eot_pkg::REG_COOLDOWN:  r_cooldown_len <= pwdata[eot_pkg::CD_W-1:0];
                eot_pkg::REG_USE_SEC:   r_use_sec      <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            eot_pkg::REG_THRESHOLD: prdata = DW'(r_threshold);
            eot_pkg::REG_ATTACK:    prdata = DW'(r_attack);
            eot_pkg::REG_RELEASE:   prdata = DW'(r_release);
            eot_pkg::REG_COOLDOWN:  prdata = DW'(r_cooldown_len);
            eot_pkg::REG_USE_SEC:   prdata = DW'(r_use_sec);
            default:                prdata = '0;
        endcase
    end

    // input rectify and attack/release choice
    t_state               r_state;
    t_state               n_state;
    logic [EW-1:0]        r_env;
    logic [AW-1:0]        r_acc;
    logic [AW-1:0]        n_acc;
    logic [GW-1:0]        r_mag;
    logic                 r_rise;
    logic signed [GW-1:0] sum;
    logic [GW-1:0]        mag;
    logic [EW-1:0]        level;
    logic                 accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign sum        = GW'(i_sample_first) + (r_use_sec ? GW'(i_sample_second) : GW'(0));
    assign mag        = sum[GW-1] ? GW'(-sum) : GW'(sum);
    assign level      = EW'(mag) << CB;

    // shared multiplier operands
    logic [CB-1:0] coeff;
    logic [MW-1:0] blend;
    logic [MW-1:0] mul_a;
    logic [MW-1:0] mul_b;
    logic [PW-1:0] prod;
    logic [AW-1:0] prod_ext;

    assign coeff    = r_rise ? r_attack : r_release;
    assign blend    = (MW'(1) << CB) - MW'(r_attack);
    assign prod_ext = AW'(prod);

    always_comb begin
        mul_a = MW'(coeff);
        mul_b = '0;
        n_acc = r_acc;
        unique case (r_state)
            ST_MUL_LO: begin
                mul_b = MW'(r_env[CB-1:0]);
                n_acc = '0;
            end
            ST_MUL_HI: begin
                mul_b = MW'(r_env[EW-1:CB]);
                n_acc = prod_ext;
            end
            ST_MUL_LVL: begin
                mul_a = r_rise ? blend : '0;
                mul_b = MW'(r_mag);
                n_acc = r_acc + (prod_ext << CB);
            end
            ST_ACC: begin
                n_acc = r_acc + (prod_ext << CB);
            end
            default: ;
        endcase
    end

    eot_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // onset decision
    eot_pkg::t_det_cfg det_cfg;
    logic              det_step;
    logic              onset;
    logic              out_free;

    assign det_cfg.threshold    = r_threshold;
    assign det_cfg.cooldown_len = r_cooldown_len;
    assign out_free             = !o_out_valid || i_out_ready;
    assign det_step             = (r_state == ST_DET) && out_free;

    eot_detect u_detect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (det_step),
        .i_env   (r_env),
        .i_cfg   (det_cfg),
        .o_onset (onset)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (accept) n_state = ST_MUL_LO;
            ST_MUL_LO:  n_state = ST_MUL_HI;
            ST_MUL_HI:  n_state = ST_MUL_LVL;
            ST_MUL_LVL: n_state = ST_ACC;
            ST_ACC:     n_state = ST_DET;
            ST_DET:     if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_env   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_ACC) begin
                r_env <= n_acc[EW+CB-1:CB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        if (accept) begin
            r_mag  <= mag;
            r_rise <= level > r_env;
        end
    end

    // output register
    logic              r_out_valid;
    logic              r_pulse;
    logic [HW-1:0]     r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (det_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (det_step) begin
            r_pulse <= onset;
            r_level <= r_env[EW-1:CB];
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_onset_pulse    = r_pulse;
    assign o_velocity       = r_pulse ? eot_pkg::VEL_FULL : '0;
    assign o_envelope_level = r_level;

endmodule
